// File: hw/rtl/ewog_pkg.sv
// Shared types and constants for the epoch write-once guard.
// Field widths, status, func and mode codes, controller/datapath structs.
// No dependencies.
package ewog_pkg;

  localparam int FUNC_W    = 2;
  localparam int LI_W      = 10;
  localparam int PI_W      = 16;
  localparam int EPOCH_W   = 64;
  localparam int STAT_W    = 3;
  localparam int LC_W      = 11;
  localparam int PC_W      = 17;
  localparam int CFG_IDX_W = 2;
  localparam int MAP_W     = 64;
  localparam int BIT_W     = 6;
  // flat slot number: layer * positions + position, with headroom
  localparam int SLOT_W    = LC_W + PC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH = 2'd2;

  // request functions
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd2;

  // result codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STAT_W-1:0] ST_BOUNDS  = 3'd2;
  localparam logic [STAT_W-1:0] ST_STATE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_CAP     = 3'd4;

  // guard modes
  localparam logic [1:0] MODE_UNCONF = 2'd0;
  localparam logic [1:0] MODE_CAP    = 2'd1;
  localparam logic [1:0] MODE_READY  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       decide;
    logic       clr_init;
    logic       clr_run;
    logic [1:0] mode;
  } ewog_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cfg_geom;
    logic cfg_init;
    logic geom_zero;
    logic cap_over;
    logic new_epoch;
    logic clr_last;
  } ewog_sts_t;

endpackage

// File: hw/rtl/ewog_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ewog_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ewog_ctrl.sv
// Controller for the epoch write-once guard: request sequencing, guard mode,
// map clearing sweep and result strobe. Depends on ewog_pkg.
module ewog_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output ewog_pkg::ewog_cmd_t cmd,
  input  ewog_pkg::ewog_sts_t sts
);
  import ewog_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DEC   = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] mode;
  logic [1:0] mode_next;
  logic       init_go;

  // initial epoch write with a usable geometry loads and clears
  assign init_go = sts.cfg_init && !sts.geom_zero && !sts.cap_over;

  // guard mode follows configuration writes
  always_comb begin
    mode_next = mode;
    if (sts.cfg_geom) begin
      mode_next = MODE_UNCONF;
    end else if (sts.cfg_init) begin
      if (sts.geom_zero) begin
        mode_next = MODE_UNCONF;
      end else if (sts.cap_over) begin
        mode_next = MODE_CAP;
      end else begin
        mode_next = MODE_READY;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DEC;
        end else if (init_go) begin
          state_next = S_CLEAR;
        end
      end
      S_DEC: begin
        state_next = sts.new_epoch ? S_CLEAR : S_IDLE;
      end
      S_CLEAR: begin
        if (!init_go && sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.load     = (state == S_IDLE) && start;
    cmd.decide   = (state == S_DEC);
    cmd.clr_init = ((state == S_DEC) && sts.new_epoch) ||
                   (init_go && (state == S_CLEAR)) ||
                   (init_go && (state == S_IDLE) && !start);
    cmd.clr_run  = (state == S_CLEAR);
    cmd.mode     = mode;
  end

  assign busy = (state != S_IDLE);

  // state, mode and result strobe; reset starts with a clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      mode  <= MODE_UNCONF;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      done  <= (state == S_DEC);
    end
  end

endmodule

// File: hw/rtl/ewog_dp.sv
// Datapath for the epoch write-once guard: geometry and epoch registers,
// slot addressing, bitmap RAM read-modify-write and clear counter.
// Depends on ewog_pkg and ewog_ram.
module ewog_dp #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ewog_pkg::ewog_cmd_t              cmd,
  output ewog_pkg::ewog_sts_t              sts,
  input  logic [ewog_pkg::FUNC_W-1:0]      func,
  input  logic [ewog_pkg::LI_W-1:0]        layer_index,
  input  logic [ewog_pkg::PI_W-1:0]        position_index,
  input  logic [ewog_pkg::EPOCH_W-1:0]     epoch_value,
  input  logic                             cfg_valid,
  input  logic [ewog_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ewog_pkg::EPOCH_W-1:0]     cfg_data,
  output logic [ewog_pkg::STAT_W-1:0]      status
);
  import ewog_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [SLOT_W-1:0] CapSlots  = SLOT_W'(MAP_W * BITMAP_WORDS);
  localparam logic [AW-1:0]     LastWord  = AW'(BITMAP_WORDS - 1);

  logic [LC_W-1:0]    layer_count;
  logic [PC_W-1:0]    position_count;
  logic [EPOCH_W-1:0] current_epoch;
  logic [SLOT_W-1:0]  geom_prod;
  logic [SLOT_W-1:0]  slot;
  logic               in_bounds;

  logic [FUNC_W-1:0]  req_func;
  logic [EPOCH_W-1:0] req_epoch;
  logic               req_inb;
  logic [BIT_W-1:0]   req_bit;
  logic [AW-1:0]      req_word;

  logic [AW-1:0]      clr_cnt;
  logic [MAP_W-1:0]   rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [MAP_W-1:0]   ram_wdata;
  logic               bit_set;
  logic               epoch_eq;
  logic               mark_ok;
  logic [STAT_W-1:0]  status_next;

  // configuration transaction decode
  assign sts.cfg_geom = cfg_valid && ((cfg_index == REG_LAYER) || (cfg_index == REG_POS));
  assign sts.cfg_init = cfg_valid && (cfg_index == REG_EPOCH);

  // geometry checks: zero size, or more slots than the map holds
  assign geom_prod     = SLOT_W'(layer_count) * SLOT_W'(position_count);
  assign sts.geom_zero = (layer_count == '0) || (position_count == '0);
  assign sts.cap_over  = geom_prod > CapSlots;

  // geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count    <= '0;
      position_count <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LAYER) begin
        layer_count <= cfg_data[LC_W-1:0];
      end
      if (cfg_index == REG_POS) begin
        position_count <= cfg_data[PC_W-1:0];
      end
    end
  end

  // epoch tag
  always_ff @(posedge clk) begin
    if (rst) begin
      current_epoch <= '0;
    end else if (sts.cfg_init && !sts.geom_zero && !sts.cap_over) begin
      current_epoch <= cfg_data;
    end else if (cmd.decide && sts.new_epoch) begin
      current_epoch <= req_epoch;
    end
  end

  // slot address from the request ports, used for the RAM read at accept
  assign slot      = SLOT_W'(layer_index) * SLOT_W'(position_count) + SLOT_W'(position_index);
  assign in_bounds = ({1'b0, layer_index} < layer_count) &&
                     ({1'b0, position_index} < position_count);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= func;
      req_epoch <= epoch_value;
      req_inb   <= in_bounds;
      req_bit   <= slot[BIT_W-1:0];
      req_word  <= slot[AW+BIT_W-1:BIT_W];
    end
  end

  // request decision on the word just read
  assign bit_set  = rdata[req_bit];
  assign epoch_eq = (req_epoch == current_epoch);

  always_comb begin
    status_next = ST_INVALID;
    mark_ok     = 1'b0;
    unique case (cmd.mode)
      MODE_UNCONF: status_next = ST_INVALID;
      MODE_CAP:    status_next = ST_CAP;
      MODE_READY: begin
        unique case (req_func)
          FUNC_MARK: begin
            priority if (!epoch_eq) begin
              status_next = ST_STATE;
            end else if (!req_inb) begin
              status_next = ST_BOUNDS;
            end else if (bit_set) begin
              status_next = ST_STATE;
            end else begin
              status_next = ST_OK;
              mark_ok     = 1'b1;
            end
          end
          FUNC_READ: begin
            priority if (!epoch_eq) begin
              status_next = ST_STATE;
            end else if (!req_inb) begin
              status_next = ST_BOUNDS;
            end else begin
              status_next = bit_set ? ST_OK : ST_STATE;
            end
          end
          FUNC_RESET: status_next = epoch_eq ? ST_INVALID : ST_OK;
          default:    status_next = ST_INVALID;
        endcase
      end
      default: status_next = ST_INVALID;
    endcase
  end

  assign sts.new_epoch = (cmd.mode == MODE_READY) && (req_func == FUNC_RESET) && !epoch_eq;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      status <= status_next;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_init) begin
      clr_cnt <= '0;
    end else if (cmd.clr_run) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt == LastWord);

  // RAM write: sweep zeros, or set the marked bit
  assign ram_we    = cmd.clr_run || (cmd.decide && mark_ok);
  assign ram_waddr = cmd.clr_run ? clr_cnt : req_word;
  assign ram_wdata = cmd.clr_run ? '0 : (rdata | (MAP_W'(1) << req_bit));

  ewog_ram #(
    .WIDTH(MAP_W),
    .DEPTH(BITMAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot[AW+BIT_W-1:BIT_W]),
    .rdata(rdata)
  );

endmodule

// File: hw/rtl/epoch_write_once_guard_unit.sv
// Top level of the epoch write-once guard.
// Joins ewog_ctrl and ewog_dp; depends on ewog_pkg.

// A request is accepted when start is high and busy is low. Its result
// appears on status with done high for one cycle, and the next request
// may be accepted in that same cycle unless a clearing pass begins; a new
// request is not taken before the last one's result. The bitmap word is
// read first, then the decision and write-back use the single RAM write
// port. The receiver cannot stall; results must be taken as they come. An
// epoch reset that changes the epoch, a write of initial_epoch with a
// usable geometry, and the release of rst each start a clearing pass,
// one word a cycle, with busy high throughout. Configuration writes are
// always ready and belong to idle periods.
module epoch_write_once_guard_unit #(
  parameter int BITMAP_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ewog_pkg::FUNC_W-1:0]    func,
  input  logic [ewog_pkg::LI_W-1:0]      layer_index,
  input  logic [ewog_pkg::PI_W-1:0]      position_index,
  input  logic [ewog_pkg::EPOCH_W-1:0]   epoch_value,
  output logic                           done,
  output logic [ewog_pkg::STAT_W-1:0]    status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ewog_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ewog_pkg::EPOCH_W-1:0]   cfg_data
);
  import ewog_pkg::*;

  ewog_cmd_t cmd;
  ewog_sts_t sts;

  // configuration transactions are taken in any cycle
  assign cfg_ready = 1'b1;

  ewog_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .sts  (sts)
  );

  ewog_dp #(
    .BITMAP_WORDS(BITMAP_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .func          (func),
    .layer_index   (layer_index),
    .position_index(position_index),
    .epoch_value   (epoch_value),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status)
  );

endmodule

// File: hw/rtl/ewog_chk.sv
// Port-level checker for the epoch write-once guard, bound to the top level.
// Depends on epoch_write_once_guard_unit ports only.
module ewog_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted request holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted request");

  // every accepted request gets its result strobe after the decision state
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing for an accepted request");

  // result strobes are never back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes back to back");

  // the map clearing pass after reset keeps the block busy
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy at the start of the clearing pass");

endmodule

bind epoch_write_once_guard_unit ewog_chk u_ewog_chk (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);
